// File: rtl/core/etp_pkg.sv
// Shared codes, constants and queue entry type of the EEPROM TLV image parser.
package etp_pkg;

	// Byte kinds reported on the result channel
	localparam logic [3:0] KIND_MAGIC   = 4'd0;
	localparam logic [3:0] KIND_VERSION = 4'd1;
	localparam logic [3:0] KIND_LENGTH  = 4'd2;
	localparam logic [3:0] KIND_TAG     = 4'd3;
	localparam logic [3:0] KIND_LONGLEN = 4'd4;
	localparam logic [3:0] KIND_VALUE   = 4'd5;
	localparam logic [3:0] KIND_STRING  = 4'd6;
	localparam logic [3:0] KIND_CRC     = 4'd7;
	localparam logic [3:0] KIND_IGNORED = 4'd8;

	// Status codes
	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_BAD_MAGIC   = 3'd1;
	localparam logic [2:0] STAT_BAD_VERSION = 3'd2;
	localparam logic [2:0] STAT_OVERRUN     = 3'd3;
	localparam logic [2:0] STAT_CRC_GOOD    = 3'd4;
	localparam logic [2:0] STAT_CRC_BAD     = 3'd5;
	localparam logic [2:0] STAT_IDLE        = 3'd6;

	// Register indexes (paddr[2])
	localparam logic REG_MAGIC   = 1'b0;
	localparam logic REG_VERSION = 1'b1;

	localparam logic [7:0] RESET_MAGIC   = 8'h56;
	localparam logic [7:0] RESET_VERSION = 8'h02;
	localparam logic [7:0] POOL_TAG      = 8'h01;
	localparam logic [7:0] CRC_POLY      = 8'h07;
	localparam logic [7:0] MIN_LENGTH    = 8'd3;
	localparam logic [8:0] POS_MAX       = 9'd511;

	// Classified byte, front to back
	typedef struct packed {
		logic       restart;
		logic [3:0] kind;
		logic [7:0] tag;
		logic [7:0] offs;
		logic [7:0] raw;
		logic [7:0] val;
		logic       send;
		logic [7:0] sidx;
		logic [2:0] status;
	} etp_item_t;

endpackage

// File: rtl/core/etp_if.sv
// Valid/ready channel interfaces for image bytes in and classified bytes out.
interface etp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       image_start;

	modport source (output valid, output data_byte, output image_start, input ready);
	modport sink (input valid, input data_byte, input image_start, output ready);
endinterface

interface etp_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] byte_kind;
	logic [7:0] tag_id;
	logic [7:0] value_offset;
	logic [7:0] value_out;
	logic       string_end;
	logic [7:0] string_index;
	logic [2:0] status;

	modport source (output valid, output byte_kind, output tag_id, output value_offset,
		output value_out, output string_end, output string_index, output status,
		input ready);
	modport sink (input valid, input byte_kind, input tag_id, input value_offset,
		input value_out, input string_end, input string_index, input status,
		output ready);
endinterface

// File: rtl/core/etp_front.sv
// Front end: holds the parse state and classifies each accepted byte.
module etp_front import etp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       image_start,
	input  logic [7:0] exp_magic,
	input  logic [7:0] exp_version,
	output etp_item_t  item
);

	typedef enum logic [2:0] {
		PH_MAGIC, PH_VERSION, PH_LENGTH, PH_TAG, PH_LONGLEN, PH_VALUE, PH_DONE
	} phase_t;

	phase_t     phase_q, ph_e, ph_n;
	logic [7:0] len_q, len_e, len_n;
	logic [8:0] pos_q, pos_e, pos_n;
	logic [7:0] tag_q, tag_e, tag_n;
	logic [7:0] rem_q, rem_e, rem_n;
	logic [7:0] off_q, off_e, off_n;
	logic [7:0] sc_q, sc_e, sc_n;
	logic [9:0] end_short, end_long;
	logic [9:0] len_w;
	logic       crc_now;

	// Restart view of the state
	always_comb begin
		ph_e  = image_start ? PH_MAGIC : phase_q;
		len_e = image_start ? 8'd0 : len_q;
		pos_e = image_start ? 9'd0 : pos_q;
		tag_e = image_start ? 8'd0 : tag_q;
		rem_e = image_start ? 8'd0 : rem_q;
		off_e = image_start ? 8'd0 : off_q;
		sc_e  = image_start ? 8'd0 : sc_q;
	end

	assign len_w     = {2'b00, len_e};
	assign end_short = {1'b0, pos_e} + {6'd0, data_byte[7:4]};
	assign end_long  = {1'b0, pos_e} + {2'b00, data_byte};
	assign crc_now   = (ph_e == PH_TAG || ph_e == PH_LONGLEN || ph_e == PH_VALUE) &&
		(pos_e == {1'b0, len_e});

	// Classification and next state
	always_comb begin
		ph_n  = ph_e;
		len_n = len_e;
		tag_n = tag_e;
		rem_n = rem_e;
		off_n = off_e;
		sc_n  = sc_e;
		pos_n = (pos_e < POS_MAX) ? pos_e + 9'd1 : pos_e;

		item         = '0;
		item.restart = image_start;
		item.raw     = data_byte;
		item.val     = data_byte;
		item.kind    = KIND_IGNORED;
		item.status  = STAT_OK;

		if (crc_now) begin
			item.kind = KIND_CRC;
			ph_n      = PH_DONE;
		end else begin
			unique case (ph_e)
				PH_MAGIC: begin
					item.kind = KIND_MAGIC;
					if (data_byte != exp_magic) begin
						item.status = STAT_BAD_MAGIC;
						ph_n        = PH_DONE;
					end else begin
						ph_n = PH_VERSION;
					end
				end
				PH_VERSION: begin
					item.kind = KIND_VERSION;
					if (data_byte != exp_version) begin
						item.status = STAT_BAD_VERSION;
						ph_n        = PH_DONE;
					end else begin
						ph_n = PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					item.kind = KIND_LENGTH;
					len_n     = data_byte;
					if (data_byte < MIN_LENGTH) begin
						item.status = STAT_OVERRUN;
						ph_n        = PH_DONE;
					end else begin
						ph_n = PH_TAG;
					end
				end
				PH_TAG: begin
					item.kind = KIND_TAG;
					item.tag  = data_byte;
					tag_n     = data_byte;
					off_n     = 8'd0;
					if (data_byte[7:4] == 4'd0) begin
						// long form: a length byte follows
						ph_n = PH_LONGLEN;
						if ({1'b0, pos_e} + 10'd1 >= len_w) item.status = STAT_OVERRUN;
					end else begin
						rem_n = {4'd0, data_byte[7:4]};
						ph_n  = PH_VALUE;
						if (end_short >= len_w) item.status = STAT_OVERRUN;
					end
				end
				PH_LONGLEN: begin
					item.kind = KIND_LONGLEN;
					item.tag  = tag_e;
					rem_n     = data_byte;
					off_n     = 8'd0;
					ph_n      = (data_byte == 8'd0) ? PH_TAG : PH_VALUE;
					if (data_byte != 8'd0 && end_long >= len_w) item.status = STAT_OVERRUN;
				end
				PH_VALUE: begin
					item.tag  = tag_e;
					item.offs = off_e;
					if (tag_e == POOL_TAG) begin
						item.kind = KIND_STRING;
						item.val  = {1'b0, data_byte[6:0]};
						item.send = data_byte[7];
						item.sidx = sc_e;
						if (data_byte[7]) sc_n = sc_e + 8'd1;
					end else begin
						item.kind = KIND_VALUE;
					end
					off_n = off_e + 8'd1;
					rem_n = rem_e - 8'd1;
					if (rem_n == 8'd0) ph_n = PH_TAG;
				end
				PH_DONE: begin
					item.kind   = KIND_IGNORED;
					item.status = STAT_IDLE;
				end
				default: begin
					item.kind   = KIND_IGNORED;
					item.status = STAT_IDLE;
					ph_n        = PH_DONE;
				end
			endcase
		end
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			len_q   <= 8'd0;
			pos_q   <= 9'd0;
			tag_q   <= 8'd0;
			rem_q   <= 8'd0;
			off_q   <= 8'd0;
			sc_q    <= 8'd0;
		end else if (accept) begin
			phase_q <= ph_n;
			len_q   <= len_n;
			pos_q   <= pos_n;
			tag_q   <= tag_n;
			rem_q   <= rem_n;
			off_q   <= off_n;
			sc_q    <= sc_n;
		end
	end

endmodule

// File: rtl/core/etp_fifo.sv
// Two-entry queue of classified bytes between front and back.
module etp_fifo import etp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  etp_item_t wdata,
	input  logic      pop,
	output etp_item_t rdata,
	output logic      full,
	output logic      empty
);

	etp_item_t  mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/etp_back.sv
// Back end: running CRC-8, CRC byte check and the output register.
module etp_back import etp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  etp_item_t q_item,
	output logic      pop,
	etp_out_if.source dout
);

	logic [7:0] crc_q;
	logic [7:0] crc_base;
	logic       valid_q;
	logic [2:0] status_n;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	assign pop        = !q_empty && (!valid_q || dout.ready);
	assign crc_base   = q_item.restart ? 8'd0 : crc_q;
	assign status_n   = (q_item.kind == KIND_CRC) ?
		((crc_base == q_item.raw) ? STAT_CRC_GOOD : STAT_CRC_BAD) : q_item.status;
	assign dout.valid = valid_q;

	// CRC accumulator and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= 8'd0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				if (q_item.kind != KIND_CRC && q_item.kind != KIND_IGNORED) begin
					crc_q <= crc8_step(crc_base, q_item.raw);
				end else begin
					crc_q <= crc_base;
				end
			end else if (dout.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (pop) begin
			dout.byte_kind    <= q_item.kind;
			dout.tag_id       <= q_item.tag;
			dout.value_offset <= q_item.offs;
			dout.value_out    <= q_item.val;
			dout.string_end   <= q_item.send;
			dout.string_index <= q_item.sidx;
			dout.status       <= status_n;
		end
	end

endmodule

// File: rtl/core/eeprom_tlv_image_parser.sv
// Top level of the EEPROM TLV image parser: config registers, front, queue, back.
//
// Usage: image bytes enter on din (data_byte, image_start) one beat per byte;
// image_start marks the first byte of an image and restarts parsing there.
// Every byte yields exactly one beat on dout: its kind, record tag, offset in
// the value, the byte (top bit cleared for string pool characters), string
// end flag and string number, and a status (header errors, overrun of the
// image length, CRC-8 result at the byte after the length, idle after done).
// The APB port holds the expected magic (0x0) and version (0x4) bytes; write
// them only while no byte is in flight.
// Path: an accepted byte is written into the queue, then popped from it into
// the dout register once dout is empty or its beat is taken.
// Throughput: one byte per cycle while the queue is not full, as the front
// classifier and the CRC step in the back end are each combinational.
// A two-beat queue sits between front and back, and dout is registered, so
// din keeps taking bytes while dout stalls until the queue holds two beats.
// Reset clears the parse state, the CRC and all beats in flight, and loads
// magic 0x56 and version 2; the first byte after reset is taken as magic.
module eeprom_tlv_image_parser import etp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	etp_in_if.sink      din,
	etp_out_if.source   dout,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] magic_q;
	logic [7:0] version_q;
	logic       accept;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;
	etp_item_t  f_item;
	etp_item_t  q_item;

	assign pready   = 1'b1;
	assign din.ready = !q_full;
	assign accept   = din.valid && !q_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= RESET_MAGIC;
			version_q <= RESET_VERSION;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_MAGIC:   magic_q <= pwdata[7:0];
				REG_VERSION: version_q <= pwdata[7:0];
				default:     magic_q <= magic_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAGIC:   prdata = {24'd0, magic_q};
			REG_VERSION: prdata = {24'd0, version_q};
			default:     prdata = 32'd0;
		endcase
	end

	etp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (din.data_byte),
		.image_start (din.image_start),
		.exp_magic   (magic_q),
		.exp_version (version_q),
		.item        (f_item)
	);

	etp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (f_item),
		.pop    (q_pop),
		.rdata  (q_item),
		.full   (q_full),
		.empty  (q_empty)
	);

	etp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_item),
		.pop     (q_pop),
		.dout    (dout)
	);

	// Checks
	a_ignored_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.byte_kind == KIND_IGNORED |-> dout.status == STAT_IDLE)
		else $error("ignored byte without idle status");

	a_crc_status: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.byte_kind == KIND_CRC |->
		dout.status == STAT_CRC_GOOD || dout.status == STAT_CRC_BAD)
		else $error("crc byte without crc status");

	a_send_string: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.string_end |-> dout.byte_kind == KIND_STRING)
		else $error("string end outside string pool");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		accept && q_empty && (!dout.valid || dout.ready) |=> ##1 dout.valid)
		else $error("accepted byte did not reach output");

endmodule
